FILE: sv/srtc_pkg.sv
// Shared types and constants of the sectioned rational transfer curve core.
`timescale 1ns / 1ps
package srtc_pkg;

   // Value format: unsigned 1.16
   localparam int VAL_W  = 17;
   localparam int FRAC_W = 16;
   localparam logic [VAL_W-1:0] ONE_Q16 = 17'h1_0000;

   // Coefficients: signed 4.12, one register per order up to NUM_COEFS
   localparam int COEF_W    = 16;
   localparam int NUM_COEFS = 5;
   localparam int ORD_W     = 3;
   localparam logic [ORD_W-1:0] ORDERS_USED_RESET = 3'd5;

   // Bend arithmetic: 1.0 as 4.12 and as 4.28, divider widths
   localparam logic [FRAC_W-1:0] BEND_ONE = 16'h1000;
   localparam int DEN_W = 32;
   localparam logic [DEN_W-1:0] DEN_ONE = 32'h1000_0000;
   localparam int QUO_W = 16;

   // Section number covers orders up to fifteen
   localparam int SEC_W = 4;
   localparam int Y_W   = 20;

   // Reciprocal multiply for the divide by the order number
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_W     = 22;
   localparam int PROD_W      = Y_W + RECIP_W;

   // Register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ORDER1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ORDER2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ORDER3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ORDER4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ORDER5 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDERS_USED = 3'd5;

   // Value between orders
   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] x;
   } val_stage_type;

   // Section, fraction and effective coefficient of one order
   typedef struct packed {
      logic              valid;
      logic [SEC_W-1:0]  sec;
      logic [FRAC_W-1:0] f;
      logic              neg;
      logic [FRAC_W-1:0] mag;
   } pre_stage_type;

   // One step of the restoring divider
   typedef struct packed {
      logic              valid;
      logic [SEC_W-1:0]  sec;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } div_stage_type;

   // Recombined value and its reciprocal product
   typedef struct packed {
      logic              valid;
      logic [Y_W-1:0]    y;
      logic [PROD_W-1:0] prod;
   } post_stage_type;

endpackage

FILE: sv/srtc_div_cell.sv
// One restoring division cell: develops a single quotient bit per cycle while enabled.
`timescale 1ns / 1ps
module srtc_div_cell
   import srtc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  div_stage_type stage_i,
   output div_stage_type stage_o
);

   div_stage_type    stage_ff;
   div_stage_type    stage_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             take;

   // Shift the remainder in a zero numerator bit and try the subtraction
   always_comb begin
      trial    = {stage_i.rem, 1'b0};
      diff     = trial - {1'b0, stage_i.den};
      take     = (trial >= {1'b0, stage_i.den});
      stage_in = stage_i;
      stage_in.rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      stage_in.quo = {stage_i.quo[QUO_W-2:0], take};
   end

   // Advance with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

FILE: sv/srtc_order.sv
// One shaping order: section split, rational bend through a divider chain, rescale.
`timescale 1ns / 1ps
module srtc_order
   import srtc_pkg::*;
#(
   parameter int ORDER = 1
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic signed [COEF_W-1:0] coef,
   input  logic [ORD_W-1:0]         orders_used,
   input  val_stage_type            stage_i,
   output val_stage_type            stage_o
);

   localparam logic [SEC_W-1:0]   ORDER_C = SEC_W'(ORDER);
   localparam logic [Y_W-1:0]     ORDER_Y = Y_W'(ORDER);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << RECIP_SHIFT) / ORDER);

   pre_stage_type    pre_ff;
   pre_stage_type    pre_in;
   div_stage_type    den_ff;
   div_stage_type    den_in;
   div_stage_type    chain [QUO_W+1];
   post_stage_type   post_ff;
   post_stage_type   post_in;
   val_stage_type    out_ff;
   val_stage_type    out_in;

   logic [Y_W-1:0]        scaled;
   logic [COEF_W-1:0]     coef_act;
   logic [COEF_W:0]       g_ext;
   logic [COEF_W:0]       g_eff;
   logic [COEF_W:0]       g_mag;
   logic [VAL_W-1:0]      dmul;
   logic [DEN_W:0]        prod_d;
   logic [FRAC_W-1:0]     nmul;
   logic [VAL_W-1:0]      q_est;
   logic [Y_W-1:0]        q_back;
   logic [Y_W-1:0]        q_rem;

   // Scale by the order, split section and fraction, flip the coefficient in odd sections
   always_comb begin
      scaled   = Y_W'(stage_i.x) * ORDER_Y;
      coef_act = (ORDER_C <= {1'b0, orders_used}) ? coef : '0;
      g_ext    = {coef_act[COEF_W-1], coef_act};
      g_eff    = scaled[FRAC_W] ? ((COEF_W+1)'(0) - g_ext) : g_ext;
      g_mag    = g_eff[COEF_W] ? ((COEF_W+1)'(0) - g_eff) : g_eff;
      pre_in.valid = stage_i.valid;
      pre_in.sec   = scaled[FRAC_W +: SEC_W];
      pre_in.f     = scaled[FRAC_W-1:0];
      pre_in.neg   = g_eff[COEF_W];
      pre_in.mag   = g_mag[COEF_W-1:0];
   end

   // Form denominator and the upper numerator word of the bend
   always_comb begin
      dmul   = pre_ff.neg ? {1'b0, pre_ff.f} : (ONE_Q16 - {1'b0, pre_ff.f});
      prod_d = (DEN_W+1)'(pre_ff.mag) * (DEN_W+1)'(dmul);
      nmul   = BEND_ONE + (pre_ff.neg ? pre_ff.mag : '0);
      den_in.valid = pre_ff.valid;
      den_in.sec   = pre_ff.sec;
      den_in.den   = DEN_ONE + prod_d[DEN_W-1:0];
      den_in.rem   = DEN_W'(pre_ff.f) * DEN_W'(nmul);
      den_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff.valid <= 1'b0;
         den_ff.valid <= 1'b0;
      end else if (en) begin
         pre_ff <= pre_in;
         den_ff <= den_in;
      end
   end

   // Divider chain, one quotient bit per cell
   assign chain[0] = den_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      srtc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .stage_i (chain[k]),
         .stage_o (chain[k+1])
      );
   end

   // Add the section back and multiply by the reciprocal of the order
   always_comb begin
      post_in.valid = chain[QUO_W].valid;
      post_in.y     = {chain[QUO_W].sec, FRAC_W'(0)} + Y_W'(chain[QUO_W].quo);
      post_in.prod  = PROD_W'(post_in.y) * PROD_W'(RECIP);
   end

   // Correct the reciprocal estimate by at most one
   always_comb begin
      q_est  = post_ff.prod[RECIP_SHIFT +: VAL_W];
      q_back = Y_W'(q_est) * ORDER_Y;
      q_rem  = post_ff.y - q_back;
      out_in.valid = post_ff.valid;
      out_in.x     = (q_rem >= ORDER_Y) ? (q_est + VAL_W'(1)) : q_est;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (en) begin
         post_ff <= post_in;
         out_ff  <= out_in;
      end
   end

   assign stage_o = out_ff;

endmodule

FILE: sv/sectioned_rational_transfer_curve_core.sv
// Top level of the sectioned rational transfer curve core.
`timescale 1ns / 1ps
// Maps an unsigned 1.16 value in [0,1] through a chain of rational shaping orders.
// Request channel: req_valid / req_stall with req_value_in; inputs above 1.0 saturate.
// Response channel: rsp_valid / rsp_stall with rsp_value_out.
// Configuration: csr_we, csr_index, csr_wdata; indexes 0..4 hold the order coefficients
// (signed 4.12), index 5 the number of orders applied. Write only while the core is idle.
// Each order registers the section split, then the bend terms, then runs its chain of divider
// cells (one per bit of the sixteen-bit quotient), then registers the recombined value and
// the rescaled result.
// Throughput: one transaction per cycle while req_stall is low.
// A two-entry output buffer sits after the last order. While it has room the whole
// pipeline advances and requests are taken even if the receiver stalls; once both
// entries are occupied and rsp_stall is high, the pipeline holds and req_stall rises.
// Reset clears all valid flags, empties the output buffer, sets every coefficient to
// zero and the order count to five.
module sectioned_rational_transfer_curve_core
   import srtc_pkg::*;
#(
   parameter int MAX_ORDERS = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VAL_W-1:0]      req_value_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VAL_W-1:0]      rsp_value_out,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic signed [COEF_W-1:0] coef_ff [NUM_COEFS];
   logic signed [COEF_W-1:0] coef_in [NUM_COEFS];
   logic [ORD_W-1:0]         orders_used_ff;
   logic [ORD_W-1:0]         orders_used_in;

   val_stage_type            link [MAX_ORDERS+1];
   logic                     en;
   logic                     push;
   logic                     pop;
   logic [VAL_W-1:0]         ent0_ff;
   logic [VAL_W-1:0]         ent0_in;
   logic [VAL_W-1:0]         ent1_ff;
   logic [VAL_W-1:0]         ent1_in;
   logic [1:0]               cnt_ff;
   logic [1:0]               cnt_in;
   logic [1:0]               cnt_mid;

   // Decode register writes
   always_comb begin
      coef_in        = coef_ff;
      orders_used_in = orders_used_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            CSR_COEF_ORDER1, CSR_COEF_ORDER2, CSR_COEF_ORDER3,
            CSR_COEF_ORDER4, CSR_COEF_ORDER5: coef_in[csr_index] = csr_wdata;
            CSR_ORDERS_USED: orders_used_in = csr_wdata[ORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
         orders_used_ff <= ORDERS_USED_RESET;
      end else begin
         coef_ff        <= coef_in;
         orders_used_ff <= orders_used_in;
      end
   end

   // Pipeline advances unless the output buffer is full and held
   assign en        = (cnt_ff != 2'd2) || !rsp_stall;
   assign req_stall = !en;

   // Saturate the incoming value to 1.0
   assign link[0].valid = req_valid;
   assign link[0].x     = (req_value_in > ONE_Q16) ? ONE_Q16 : req_value_in;

   // Chain of shaping orders; orders without a register use a zero coefficient
   for (genvar n = 0; n < MAX_ORDERS; n++) begin : g_order
      logic signed [COEF_W-1:0] coef_sel;

      if (n < NUM_COEFS) begin : g_coef
         assign coef_sel = coef_ff[n];
      end else begin : g_zero
         assign coef_sel = '0;
      end

      srtc_order #(
         .ORDER (n + 1)
      ) u_order (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .coef        (coef_sel),
         .orders_used (orders_used_ff),
         .stage_i     (link[n]),
         .stage_o     (link[n+1])
      );
   end

   // Two-entry output buffer: drop the head on pop, append on push
   assign push = en && link[MAX_ORDERS].valid;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      cnt_mid = cnt_ff;
      if (pop) begin
         ent0_in = ent1_ff;
         cnt_mid = cnt_ff - 2'd1;
      end
      cnt_in = cnt_mid;
      if (push) begin
         if (cnt_mid == 2'd0) begin
            ent0_in = link[MAX_ORDERS].x;
         end else begin
            ent1_in = link[MAX_ORDERS].x;
         end
         cnt_in = cnt_mid + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   assign rsp_valid     = (cnt_ff != 2'd0);
   assign rsp_value_out = ent0_ff;

endmodule

FILE: sv/srtc_checker.sv
// Port-level checks of the sectioned rational transfer curve core, bound to the top level.
`timescale 1ns / 1ps
module srtc_checker
   import srtc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [VAL_W-1:0] rsp_value_out
);

   // A held response stays valid and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_out))
      else $error("response changed while stalled");

   // Requests are held back only while a response is waiting and stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   // Results never exceed 1.0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value_out <= ONE_Q16)
      else $error("response above one");

   // Output buffer is empty straight after reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sectioned_rational_transfer_curve_core srtc_checker u_checker (.*);

FILE: test/sectioned_rational_transfer_curve_core_tb.sv
// Self-checking testbench for the sectioned rational transfer curve core.
`timescale 1ns / 1ps
module sectioned_rational_transfer_curve_core_tb;
   import srtc_pkg::*;

   localparam int MAX_ORDERS = 5;
   localparam int PIPE_LATENCY = 20 * MAX_ORDERS + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS = 90;
   localparam int FILL_PHASE = 4;
   localparam int FILL_ITEMS = 250;
   localparam longint UNIT_Q16 = 64'sd65536;
   localparam longint UNIT_Q28 = 64'sd268435456;
   localparam longint ONE_Q12 = 64'sd4096;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam logic [CSR_DATA_W-1:0] COEF_MAX = 16'h7FFF;
   localparam logic [CSR_DATA_W-1:0] COEF_MIN = 16'h8000;
   localparam logic [CSR_DATA_W-1:0] COEF_PLUS_ONE = 16'h1000;
   localparam logic [CSR_DATA_W-1:0] COEF_MINUS_ONE = 16'hF000;
   localparam logic [VAL_W-1:0] VALUE_ALL_ONES = 17'h1_FFFF;

   typedef enum logic {ROW_WRITE, ROW_VALUE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic [VAL_W-1:0]      value;
      logic                  known;
      logic [VAL_W-1:0]      result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [VAL_W-1:0] req_value_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VAL_W-1:0] rsp_value_out;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the register file
   logic signed [COEF_W-1:0] coef_shadow [NUM_COEFS];
   logic [ORD_W-1:0] orders_shadow;

   logic [VAL_W-1:0] pending_curve_values [$];
   stim_row_type directed_rows [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;
   bit long_hold = 1'b0;
   bit csr_active = 1'b0;

   sectioned_rational_transfer_curve_core #(
      .MAX_ORDERS(MAX_ORDERS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value_in(req_value_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value_out(rsp_value_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Walk the value through every active order: split, bend, recombine, rescale
   function automatic logic [VAL_W-1:0] transfer_curve_out(input logic [VAL_W-1:0] value);
      longint x, scaled, sec, f, g, num, den, bent;
      int n, count;
      x = value;
      if (x > UNIT_Q16) x = UNIT_Q16;
      count = orders_shadow;
      if (count > MAX_ORDERS) count = MAX_ORDERS;
      for (n = 1; n <= count; n++) begin
         scaled = x * n;
         sec = scaled >>> 16;
         f = scaled & 64'hFFFF;
         g = 0;
         if (n <= NUM_COEFS) g = coef_shadow[n-1];
         if (sec[0]) g = -g;
         if (g >= 0) begin
            den = UNIT_Q28 + g * (UNIT_Q16 - f);
            num = f << 28;
         end else begin
            den = UNIT_Q28 - g * f;
            num = (f * (ONE_Q12 - g)) << 16;
         end
         bent = num / den;
         x = ((sec << 16) + bent) / n;
      end
      return x[VAL_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_coef();
      case ($urandom_range(0, 6))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3: return COEF_PLUS_ONE;
         4: return COEF_MINUS_ONE;
         5: return CSR_DATA_W'($urandom_range(0, 16384) - 8192);
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      int n, k, v;
      case ($urandom_range(0, 9))
         0: return ($urandom_range(0, 1) != 0) ? ONE_Q16 : '0;
         1: return VAL_W'($urandom_range(ONE_Q16 + 1, VALUE_ALL_ONES));
         2, 3: begin
            // land on or next to a section boundary
            n = $urandom_range(1, MAX_ORDERS);
            k = $urandom_range(0, n);
            v = k * ONE_Q16 / n + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            return VAL_W'(v);
         end
         default: return VAL_W'($urandom_range(0, ONE_Q16));
      endcase
   endfunction

   task automatic add_value(input logic [VAL_W-1:0] v);
      directed_rows.push_back('{ROW_VALUE, '0, '0, v, 1'b0, '0});
   endtask

   task automatic add_known(input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] r);
      directed_rows.push_back('{ROW_VALUE, '0, '0, v, 1'b1, r});
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      directed_rows.push_back('{ROW_WRITE, idx, d, '0, 1'b0, '0});
   endtask

   // Drop valid and hold until every outstanding transaction has returned
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_curve_values.size() != 0) @(posedge clock);
   endtask

   // Write one register and mirror it into the shadow copy; caller lowers csr_we
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      if (idx <= CSR_COEF_ORDER5) coef_shadow[idx] = d;
      else if (idx == CSR_ORDERS_USED) orders_shadow = d[ORD_W-1:0];
   endtask

   // Offer one transaction after a random gap (none when the sender is steady); log its expectation on acceptance
   task automatic push_value(input logic [VAL_W-1:0] v, input logic known,
                             input logic [VAL_W-1:0] r);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value_in <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_curve_values.push_back(known ? r : transfer_curve_out(v));
   endtask

   // Receiver: stall at random, take one response, compare with the oldest expectation
   initial begin
      int stall_cycles;
      logic [VAL_W-1:0] expected_value;
      forever begin
         if (long_hold) begin
            stall_cycles = LONG_HOLD_CYCLES;
            long_hold = 1'b0;
         end else begin
            stall_cycles = receiver_steady ? 0 : $urandom_range(0, 8);
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && reset === 1'b0));
         if (pending_curve_values.size() == 0) begin
            $error("unexpected response: value_out actual %0d", rsp_value_out);
            mismatch_count++;
         end else begin
            expected_value = pending_curve_values.pop_front();
            if (rsp_value_out !== expected_value) begin
               $error("value_out expected %0d actual %0d", expected_value, rsp_value_out);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int p, i, items;
      stim_row_type row;
      for (i = 0; i < NUM_COEFS; i++) coef_shadow[i] = '0;
      orders_shadow = ORDERS_USED_RESET;

      // After reset every coefficient is zero, so the curve is the identity
      add_known('0, '0);
      add_known(ONE_Q16, ONE_Q16);
      add_known(VALUE_ALL_ONES, ONE_Q16);
      add_known(ONE_Q16 + 1, ONE_Q16);
      add_known(17'd1, 17'd1);
      add_known(ONE_Q16 - 1, ONE_Q16 - 1);
      // Extremes of the coefficients, including the most negative one in an odd section
      add_write(CSR_COEF_ORDER1, COEF_MAX);
      add_write(CSR_COEF_ORDER2, COEF_MIN);
      add_write(CSR_COEF_ORDER3, COEF_PLUS_ONE);
      add_write(CSR_COEF_ORDER4, COEF_MINUS_ONE);
      add_write(CSR_COEF_ORDER5, COEF_MAX);
      add_known(ONE_Q16, ONE_Q16);
      add_known('0, '0);
      add_value(17'd32768);
      add_value(17'd21845);
      add_value(17'd43690);
      add_value(17'd49152);
      add_value(17'd12345);
      // No orders: saturated input passes unchanged
      add_write(CSR_ORDERS_USED, 16'd0);
      add_known(17'd40000, 17'd40000);
      add_known(17'd100000, ONE_Q16);
      // Order count above the limit is clamped
      add_write(CSR_ORDERS_USED, 16'd7);
      add_value(17'd30000);
      // Unmapped registers are ignored
      add_write(CSR_UNMAPPED_LO, 16'hFFFF);
      add_write(CSR_UNMAPPED_HI, 16'hFFFF);
      add_value(17'd30000);
      // Single order with a negative coefficient in section zero
      add_write(CSR_ORDERS_USED, 16'd1);
      add_write(CSR_COEF_ORDER1, COEF_MIN);
      add_value(17'd50000);
      add_value(ONE_Q16 - 1);
      add_value(17'd1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part
      foreach (directed_rows[j]) begin
         row = directed_rows[j];
         if (row.kind == ROW_WRITE) begin
            if (!csr_active) drain_pipeline();
            csr_active = 1'b1;
            write_register(row.index, row.data);
         end else begin
            if (csr_active) csr_we <= 1'b0;
            csr_active = 1'b0;
            push_value(row.value, row.known, row.result);
         end
      end

      // Random part: a fresh register setting per phase
      for (p = 0; p < RANDOM_PHASES; p++) begin
         drain_pipeline();
         for (i = 0; i < NUM_COEFS; i++) begin
            if (p == 0) write_register(CSR_IDX_W'(CSR_COEF_ORDER1 + i), COEF_MAX);
            else if (p == 1) write_register(CSR_IDX_W'(CSR_COEF_ORDER1 + i), COEF_MIN);
            else write_register(CSR_IDX_W'(CSR_COEF_ORDER1 + i), pick_coef());
         end
         if (p < 2) write_register(CSR_ORDERS_USED, CSR_DATA_W'(MAX_ORDERS));
         else if (p == 2) write_register(CSR_ORDERS_USED, '0);
         else write_register(CSR_ORDERS_USED, CSR_DATA_W'($urandom_range(0, 7)));
         if (p % 4 == 3) begin
            write_register(CSR_UNMAPPED_LO, CSR_DATA_W'($urandom));
            write_register(CSR_UNMAPPED_HI, CSR_DATA_W'($urandom));
         end
         csr_we <= 1'b0;

         // Traffic settings per phase; in the fill phase the sender streams while the receiver holds off
         sender_steady = (p % 3 == 2) || (p == FILL_PHASE);
         receiver_steady = (p % 3 == 2);
         long_hold = (p == FILL_PHASE);
         items = (p == FILL_PHASE) ? FILL_ITEMS : PHASE_ITEMS;
         for (i = 0; i < items; i++) push_value(pick_value(), 1'b0, '0);
      end

      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      drain_pipeline();
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
